// ===== rtl/ctl_pkg.sv =====
`default_nettype none

package ctl_pkg;

  // Default lexeme length limit in bytes
  localparam int MAX_TOKEN_LEN = 32;

  // Number of keywords and head bytes kept per lexeme
  localparam int KW_COUNT   = 32;
  localparam int HEAD_BYTES = 8;

  // Byte codes used by the scanner
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_PIPE  = 8'h7c;
  localparam logic [7:0] CH_RBRC  = 8'h7d;

  // Scanner modes, one-hot
  typedef enum logic [5:0] {
    MODE_NORMAL     = 6'b000001,
    MODE_SLASH      = 6'b000010,
    MODE_LINE_CMT   = 6'b000100,
    MODE_BLOCK_CMT  = 6'b001000,
    MODE_BLOCK_STAR = 6'b010000,
    MODE_DIRECTIVE  = 6'b100000
  } mode_e;

  // Token classes as reported on the output
  typedef enum logic [3:0] {
    CLS_ARITH      = 4'd0,
    CLS_RELATIONAL = 4'd1,
    CLS_KEYWORD    = 4'd2,
    CLS_LOGICAL    = 4'd3,
    CLS_SPECIAL    = 4'd4,
    CLS_NUMERIC    = 4'd5,
    CLS_IDENT      = 4'd6,
    CLS_LITERAL    = 4'd7,
    CLS_TOO_LONG   = 4'd8
  } token_class_e;

  // One result item
  typedef struct packed {
    logic         last;
    logic [63:0]  head;
    logic [5:0]   len;
    logic [9:0]   col;
    logic [15:0]  row;
    logic [4:0]   kw;
    token_class_e cls;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } kw_hit_t;

  typedef struct packed {
    logic         hit;
    token_class_e cls;
  } delim_cls_t;

  // Keyword text, first byte in the low bits, zero padded
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h6f747561,         64'h746c7561666564,   64'h64656e676973,     64'h6d756e65,
    64'h6e7265747865,     64'h726f66,           64'h7265747369676572, 64'h6669,
    64'h65736c65,         64'h746e69,           64'h656c696877,       64'h6f64,
    64'h6b61657262,       64'h65756e69746e6f63, 64'h656c62756f64,     64'h74616f6c66,
    64'h6e7275746572,     64'h72616863,         64'h65736163,         64'h74736e6f63,
    64'h666f657a6973,     64'h676e6f6c,         64'h74726f6873,       64'h66656465707974,
    64'h686374697773,     64'h64656e6769736e75, 64'h64696f76,         64'h636974617473,
    64'h746375727473,     64'h6f746f67,         64'h6e6f696e75,       64'h656c6974616c6f76
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd7, 4'd6, 4'd4, 4'd6, 4'd3, 4'd8, 4'd2,
    4'd4, 4'd3, 4'd5, 4'd2, 4'd5, 4'd8, 4'd6, 4'd5,
    4'd6, 4'd4, 4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd7,
    4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4, 4'd5, 4'd8
  };

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha_u(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a)) ||
           (b == CH_UNDER);
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    logic r;
    unique case (b) inside
      CH_SPACE, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_COMMA, CH_DOT, CH_SEMI,
      CH_COLON, CH_GT, CH_LT, CH_EQ, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK,
      CH_LBRC, CH_RBRC, CH_DOLL, CH_NL: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Class of a one-byte delimiter token; minus, star, equals and dollar fit none
  function automatic delim_cls_t delim_class(input logic [7:0] b);
    delim_cls_t r;
    r.hit = 1'b1;
    unique case (b) inside
      CH_PLUS:  r.cls = CLS_ARITH;
      CH_LT, CH_GT: r.cls = CLS_RELATIONAL;
      CH_LPAR, CH_RPAR, CH_COMMA, CH_SEMI, CH_COLON, CH_LBRC, CH_RBRC,
      CH_LBRK, CH_RBRK, CH_DOT: r.cls = CLS_SPECIAL;
      default: begin
        r.hit = 1'b0;
        r.cls = CLS_ARITH;
      end
    endcase
    return r;
  endfunction

  // Parallel keyword match; the head is zero padded so text and length decide
  function automatic kw_hit_t kw_lookup(input logic [63:0] text, input logic [3:0] len);
    kw_hit_t r;
    r = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if ((text == KW_TEXT[k]) && (len == KW_LEN[k])) begin
        r.hit = 1'b1;
        r.idx = 5'(k);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/c_token_lexer_unit.sv =====
// C token lexer: splits C source text into classified tokens.
// Slave channel s_axis: one source byte per item in tdata, tlast marks the
// final byte of a file. After it any pending lexeme is flushed and the lexer
// returns to its file-head state for the next file.
// Master channel m_axis: one token per item, tlast set on the last token
// caused by an input byte. A byte yields zero, one or two tokens.
// A token is scanned from the input register and written into the output
// queue, from which it is offered on m_axis.
// Throughput: one byte per cycle while the queue has room for two more tokens,
// set by the single registered pass from the input register through the
// scanner into the output queue; a two-token byte needs two output transfers.
// The four-entry output queue parts the two sides: while the receiver stalls
// bytes are still taken until the queue may not hold two more tokens, then
// s_axis_tready_o drops until the receiver drains it.
// Reset (rst_ni low, asynchronous) empties the input register and the queue
// and puts the lexer at the head of a file: line 0, column 1. No clearing
// pass is needed.
`default_nettype none

module c_token_lexer_unit #(
  parameter int MaxTokenLen = ctl_pkg::MAX_TOKEN_LEN
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,  // [7:0] char_in
  input  wire logic         s_axis_tlast_i,  // end_of_input
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [3:0] token_class, [8:4] keyword_index, [24:9] token_row, [34:25] token_col,
  // [40:35] token_len, [104:41] head_chars, [111:105] zero
  output logic [111:0]      m_axis_tdata_o,
  output logic              m_axis_tlast_o   // last_of_run
);

  localparam int LenW = $clog2(MaxTokenLen + 1);
  localparam logic [5:0] TooLongLen = (MaxTokenLen > 63) ? 6'd63 : 6'(MaxTokenLen);

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_char_q;
  logic       in_eoi_q;
  logic       proc;
  logic       s_acc;

  // Scanner state
  ctl_pkg::mode_e mode_q, mode_d;
  logic            at_head_q, at_head_d;
  logic [LenW-1:0] len_q, len_d;
  logic            too_long_q, too_long_d;
  logic [63:0]     head_q, head_d;
  logic [7:0]      last_q, last_d;
  logic            digits_q, digits_d;
  logic            ident_q, ident_d;
  logic [15:0]     line_q, line_d;
  logic [9:0]      col_q, col_d;
  logic [9:0]      start_q, start_d;

  // Output queue
  ctl_pkg::result_t fifo_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       m_acc;

  // Scan results
  ctl_pkg::result_t res_lex, res_dlm;
  logic             lex_emit, dlm_emit;

  assign proc            = in_vld_q && (cnt_q <= 3'd2);
  assign s_axis_tready_o = !in_vld_q || proc;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc           = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    if (s_acc) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end
  end

  // Scanner: mode step, lexeme store, classification, counters
  always_comb begin
    logic [7:0]          b;
    logic                nb;
    logic                count_line;
    logic                flush;
    logic                store;
    logic [LenW-1:0]     lx_len;
    logic [6:0]          lx_len7;
    logic                lx_too_long;
    logic [63:0]         lx_head;
    logic [7:0]          lx_last;
    logic                lx_digits;
    logic                lx_ident;
    logic [9:0]          lx_start;
    logic                cls_hit;
    ctl_pkg::token_class_e cls;
    ctl_pkg::kw_hit_t    kwh;
    ctl_pkg::delim_cls_t dc;

    b          = in_char_q;
    nb         = 1'b0;
    count_line = 1'b1;
    flush      = in_eoi_q;
    store      = 1'b0;
    dlm_emit   = 1'b0;
    mode_d     = mode_q;
    at_head_d  = at_head_q;
    dc         = ctl_pkg::delim_class(b);

    unique case (mode_q)
      ctl_pkg::MODE_DIRECTIVE: begin
        count_line = 1'b0;
        if (b == ctl_pkg::CH_NL) mode_d = ctl_pkg::MODE_NORMAL;
      end
      ctl_pkg::MODE_LINE_CMT: begin
        if (b == ctl_pkg::CH_NL) mode_d = ctl_pkg::MODE_NORMAL;
      end
      ctl_pkg::MODE_BLOCK_CMT: begin
        if (b == ctl_pkg::CH_STAR) mode_d = ctl_pkg::MODE_BLOCK_STAR;
      end
      ctl_pkg::MODE_BLOCK_STAR: begin
        if (b == ctl_pkg::CH_SLASH) begin
          mode_d = ctl_pkg::MODE_NORMAL;
        end else if (b != ctl_pkg::CH_STAR) begin
          mode_d = ctl_pkg::MODE_BLOCK_CMT;
        end
      end
      ctl_pkg::MODE_SLASH: begin
        if (b == ctl_pkg::CH_SLASH) begin
          mode_d = ctl_pkg::MODE_LINE_CMT;
        end else if (b == ctl_pkg::CH_STAR) begin
          mode_d = ctl_pkg::MODE_BLOCK_CMT;
        end else begin
          mode_d = ctl_pkg::MODE_NORMAL;
          nb     = 1'b1;
        end
      end
      default: begin
        mode_d = ctl_pkg::MODE_NORMAL;
        if (at_head_q && (b == ctl_pkg::CH_HASH)) begin
          mode_d = ctl_pkg::MODE_DIRECTIVE;
        end else begin
          at_head_d = 1'b0;
          nb        = 1'b1;
        end
      end
    endcase

    // Byte in normal text: slash, delimiter, leading tab or lexeme byte
    if (nb) begin
      if (b == ctl_pkg::CH_SLASH) begin
        flush  = 1'b1;
        mode_d = ctl_pkg::MODE_SLASH;
      end else if (ctl_pkg::is_delim(b)) begin
        flush    = 1'b1;
        dlm_emit = (b != ctl_pkg::CH_SPACE) && (b != ctl_pkg::CH_NL) && dc.hit;
      end else if (!((b == ctl_pkg::CH_TAB) && (len_q == '0))) begin
        store = 1'b1;
      end
    end

    // Lexeme after this byte is stored
    lx_len      = len_q;
    lx_too_long = too_long_q;
    lx_head     = head_q;
    lx_last     = last_q;
    lx_digits   = digits_q;
    lx_ident    = ident_q;
    lx_start    = start_q;
    if (store) begin
      if (len_q == '0) lx_start = col_q;
      if (len_q < LenW'(MaxTokenLen)) begin
        lx_len  = len_q + LenW'(1);
        lx_last = b;
        if (len_q == '0) begin
          lx_head   = {56'b0, b};
          lx_digits = ctl_pkg::is_digit(b);
          lx_ident  = ctl_pkg::is_alpha_u(b);
        end else begin
          if (len_q < LenW'(ctl_pkg::HEAD_BYTES)) lx_head[8*len_q[2:0] +: 8] = b;
          lx_digits = digits_q && ctl_pkg::is_digit(b);
          lx_ident  = ident_q && (ctl_pkg::is_alpha_u(b) || ctl_pkg::is_digit(b));
        end
      end else begin
        lx_too_long = 1'b1;
      end
    end

    // Classify the lexeme in priority order
    lx_len7 = 7'(lx_len);
    kwh     = ctl_pkg::kw_lookup(lx_head, lx_len7[3:0]);
    cls_hit = 1'b1;
    if (lx_too_long) begin
      cls = ctl_pkg::CLS_TOO_LONG;
    end else if (kwh.hit && (lx_len7 <= 7'd8)) begin
      cls = ctl_pkg::CLS_KEYWORD;
    end else if ((lx_len7 == 7'd2) &&
                 ((lx_head[15:0] == {ctl_pkg::CH_AMP, ctl_pkg::CH_AMP}) ||
                  (lx_head[15:0] == {ctl_pkg::CH_PIPE, ctl_pkg::CH_PIPE}))) begin
      cls = ctl_pkg::CLS_LOGICAL;
    end else if (lx_digits) begin
      cls = ctl_pkg::CLS_NUMERIC;
    end else if (lx_ident) begin
      cls = ctl_pkg::CLS_IDENT;
    end else if ((lx_len7 >= 7'd2) && (lx_head[7:0] == ctl_pkg::CH_QUOTE) &&
                 (lx_last == ctl_pkg::CH_QUOTE)) begin
      cls = ctl_pkg::CLS_LITERAL;
    end else begin
      cls     = ctl_pkg::CLS_ARITH;
      cls_hit = 1'b0;
    end

    lex_emit     = flush && (lx_len != '0) && cls_hit;
    res_lex.last = !dlm_emit;
    res_lex.head = lx_head;
    res_lex.len  = lx_too_long ? TooLongLen : ((lx_len7 > 7'd63) ? 6'd63 : lx_len7[5:0]);
    res_lex.col  = lx_start;
    res_lex.row  = line_q;
    res_lex.kw   = (cls == ctl_pkg::CLS_KEYWORD) ? kwh.idx : 5'd0;
    res_lex.cls  = cls;

    res_dlm.last = 1'b1;
    res_dlm.head = {56'b0, b};
    res_dlm.len  = 6'd1;
    res_dlm.col  = col_q;
    res_dlm.row  = line_q;
    res_dlm.kw   = 5'd0;
    res_dlm.cls  = dc.cls;

    len_d      = flush ? '0 : lx_len;
    too_long_d = flush ? 1'b0 : lx_too_long;
    head_d     = lx_head;
    last_d     = lx_last;
    digits_d   = lx_digits;
    ident_d    = lx_ident;
    start_d    = lx_start;

    // Line and column counters, saturating
    line_d = line_q;
    col_d  = col_q;
    if (b == ctl_pkg::CH_NL) begin
      col_d = 10'd1;
      if (count_line && (line_q != 16'hffff)) line_d = line_q + 16'd1;
    end else if (col_q != 10'h3ff) begin
      col_d = col_q + 10'd1;
    end

    // End of file: back to the file-head state
    if (in_eoi_q) begin
      mode_d     = ctl_pkg::MODE_NORMAL;
      at_head_d  = 1'b1;
      len_d      = '0;
      too_long_d = 1'b0;
      line_d     = 16'd0;
      col_d      = 10'd1;
      start_d    = 10'd0;
    end
  end

  // Output queue pointers
  always_comb begin
    logic [1:0] n_push;
    n_push   = proc ? (2'(lex_emit) + 2'(dlm_emit)) : 2'd0;
    wr_ptr_d = wr_ptr_q + n_push;
    rd_ptr_d = m_acc ? rd_ptr_q + 2'd1 : rd_ptr_q;
    cnt_d    = cnt_q + 3'(n_push) - 3'(m_acc);
  end

  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign m_axis_tlast_o  = fifo_q[rd_ptr_q].last;
  assign m_axis_tdata_o  = {7'b0, fifo_q[rd_ptr_q].head, fifo_q[rd_ptr_q].len,
                            fifo_q[rd_ptr_q].col, fifo_q[rd_ptr_q].row,
                            fifo_q[rd_ptr_q].kw, fifo_q[rd_ptr_q].cls};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      mode_q     <= ctl_pkg::MODE_NORMAL;
      at_head_q  <= 1'b1;
      len_q      <= '0;
      too_long_q <= 1'b0;
      line_q     <= 16'd0;
      col_q      <= 10'd1;
      start_q    <= 10'd0;
      wr_ptr_q   <= 2'd0;
      rd_ptr_q   <= 2'd0;
      cnt_q      <= 3'd0;
    end else begin
      in_vld_q <= in_vld_d;
      if (proc) begin
        mode_q     <= mode_d;
        at_head_q  <= at_head_d;
        len_q      <= len_d;
        too_long_q <= too_long_d;
        line_q     <= line_d;
        col_q      <= col_d;
        start_q    <= start_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_char_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tlast_i;
    end
    if (proc) begin
      head_q   <= head_d;
      last_q   <= last_d;
      digits_q <= digits_d;
      ident_q  <= ident_d;
      if (lex_emit) fifo_q[wr_ptr_q] <= res_lex;
      if (dlm_emit) fifo_q[wr_ptr_q + 2'(lex_emit)] <= res_dlm;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/c_token_lexer_unit_test.sv =====
`default_nettype none

module c_token_lexer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXL        = ctl_pkg::MAX_TOKEN_LEN;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 20;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 90;

  // One source byte waiting to be sent
  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
  } src_byte_t;

  // One token as the lexer should report it
  typedef struct packed {
    ctl_pkg::token_class_e cls;
    logic [4:0]   kw;
    logic [15:0]  row;
    logic [9:0]   col;
    logic [5:0]   len;
    logic [63:0]  head;
    logic         last;
  } lex_token_t;

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata  = '0;
  logic         s_tlast  = 1'b0;
  logic         m_ready  = 1'b0;
  logic         hold_on  = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [111:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;

  src_byte_t  byte_q[$];
  lex_token_t token_q[$];
  lex_token_t step_toks[$];

  int mismatches  = 0;
  int bytes_taken = 0;
  int tokens_seen = 0;
  int idle_cycles = 0;
  int run_cycles  = 0;
  int send_gap    = 0;
  int stall_left  = 0;

  // No idling on either side for one quarter of every 256 bytes
  wire no_idle = (bytes_taken % 256) >= 192;

  // Token text sets
  string kw_names[32] = '{
    "auto", "default", "signed", "enum", "extern", "for", "register", "if",
    "else", "int", "while", "do", "break", "continue", "double", "float",
    "return", "char", "case", "const", "sizeof", "long", "short", "typedef",
    "switch", "unsigned", "void", "static", "struct", "goto", "union", "volatile"
  };
  string arith_ops[2] = '{"+", "<-"};
  string rel_ops[6]   = '{"<", ">", "<=", ">=", "==", "!="};
  string logic_ops[2] = '{"&&", "||"};
  string spec_ops[10] = '{"(", ")", ",", ";", ":", "{", "}", "[", "]", "."};
  string split_chars  = " +-*/,.;:><=()[]{}$\n";

  // Character pools for stimulus
  string word_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string word_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string digits    = "0123456789";
  string lit_pool  = "abcxyz019_!?'#";
  string cmt_pool  = "ab x*/\n\t";
  string sep_pool  = "   \n\n;,(){}+<>.";

  // Lexer state as predicted
  ctl_pkg::mode_e scan_mode;
  logic [7:0]  lex_buf [MAXL];
  int          lex_len;
  logic [15:0] line_no;
  logic [9:0]  col_no;
  logic [9:0]  tok_col;
  bit          too_long;
  bit          file_head;

  c_token_lexer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------------

  function automatic void reset_lexer();
    scan_mode = ctl_pkg::MODE_NORMAL;
    lex_len   = 0;
    line_no   = '0;
    col_no    = 10'd1;
    tok_col   = '0;
    too_long  = 1'b0;
    file_head = 1'b1;
  endfunction

  function automatic bit is_num_char(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_word_start(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == ctl_pkg::CH_UNDER;
  endfunction

  function automatic bit is_split(logic [7:0] b);
    for (int k = 0; k < split_chars.len(); k++)
      if (split_chars[k] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit text_eq(logic [7:0] txt [MAXL], int n, string s);
    if (s.len() != n) return 1'b0;
    for (int k = 0; k < n; k++)
      if (txt[k] != s[k]) return 1'b0;
    return 1'b1;
  endfunction

  // Class of a finished lexeme, in priority order; 0 when it fits none
  function automatic bit classify(input logic [7:0] txt [MAXL], input int n,
                                  output ctl_pkg::token_class_e cls,
                                  output logic [4:0] kw);
    bit ok;
    cls = ctl_pkg::CLS_ARITH;
    kw  = '0;
    if (n == 0) return 1'b0;
    foreach (arith_ops[i]) if (text_eq(txt, n, arith_ops[i])) return 1'b1;
    cls = ctl_pkg::CLS_RELATIONAL;
    foreach (rel_ops[i]) if (text_eq(txt, n, rel_ops[i])) return 1'b1;
    cls = ctl_pkg::CLS_KEYWORD;
    foreach (kw_names[i]) begin
      if (text_eq(txt, n, kw_names[i])) begin
        kw = 5'(i);
        return 1'b1;
      end
    end
    cls = ctl_pkg::CLS_LOGICAL;
    foreach (logic_ops[i]) if (text_eq(txt, n, logic_ops[i])) return 1'b1;
    cls = ctl_pkg::CLS_SPECIAL;
    foreach (spec_ops[i]) if (text_eq(txt, n, spec_ops[i])) return 1'b1;
    cls = ctl_pkg::CLS_NUMERIC;
    ok = 1'b1;
    for (int k = 0; k < n; k++) if (!is_num_char(txt[k])) ok = 1'b0;
    if (ok) return 1'b1;
    cls = ctl_pkg::CLS_IDENT;
    ok = is_word_start(txt[0]);
    for (int k = 1; k < n; k++)
      if (!is_word_start(txt[k]) && !is_num_char(txt[k])) ok = 1'b0;
    if (ok) return 1'b1;
    cls = ctl_pkg::CLS_LITERAL;
    return n >= 2 && txt[0] == ctl_pkg::CH_QUOTE && txt[n-1] == ctl_pkg::CH_QUOTE;
  endfunction

  function automatic void emit_token(ctl_pkg::token_class_e cls, logic [4:0] kw,
                                     logic [15:0] row, logic [9:0] col, int n,
                                     logic [7:0] txt [MAXL]);
    lex_token_t t;
    if (step_toks.size() >= 2) return;
    t      = '0;
    t.cls  = cls;
    t.kw   = kw;
    t.row  = row;
    t.col  = col;
    t.len  = (n > 63) ? 6'd63 : 6'(n);
    for (int k = 0; k < n && k < 8; k++) t.head[8*k +: 8] = txt[k];
    step_toks.push_back(t);
  endfunction

  function automatic void flush_lexeme(logic [15:0] row);
    ctl_pkg::token_class_e cls;
    logic [4:0]   kw;
    if (lex_len != 0) begin
      if (too_long)
        emit_token(ctl_pkg::CLS_TOO_LONG, '0, row, tok_col, MAXL, lex_buf);
      else if (classify(lex_buf, lex_len, cls, kw))
        emit_token(cls, kw, row, tok_col, lex_len, lex_buf);
    end
    lex_len  = 0;
    too_long = 1'b0;
  endfunction

  // A byte seen outside comments and directives
  function automatic void code_byte(logic [7:0] b, logic [15:0] row, logic [9:0] colm);
    ctl_pkg::token_class_e cls;
    logic [4:0]   kw;
    logic [7:0]   one [MAXL];
    foreach (one[i]) one[i] = '0;
    if (b == ctl_pkg::CH_SLASH) begin
      flush_lexeme(row);
      scan_mode = ctl_pkg::MODE_SLASH;
    end else if (is_split(b)) begin
      flush_lexeme(row);
      // non-blank delimiters are tokens of their own
      if (b != ctl_pkg::CH_SPACE && b != ctl_pkg::CH_NL) begin
        one[0] = b;
        if (classify(one, 1, cls, kw)) emit_token(cls, kw, row, colm, 1, one);
      end
    end else if (b == ctl_pkg::CH_TAB && lex_len == 0) begin
      // leading tab is blank
    end else begin
      if (lex_len == 0) tok_col = colm;
      if (lex_len < MAXL) begin
        lex_buf[lex_len] = b;
        lex_len++;
      end else begin
        too_long = 1'b1;
      end
    end
  endfunction

  // Works out the tokens that one accepted byte causes and queues them
  function automatic void predict_byte(logic [7:0] b, logic eoi);
    logic [15:0] row;
    logic [9:0]  colm;
    bit          count_line;
    lex_token_t  t;
    row        = line_no;
    colm       = col_no;
    count_line = 1'b1;
    step_toks.delete();
    case (scan_mode)
      ctl_pkg::MODE_DIRECTIVE: begin
        count_line = 1'b0;
        if (b == ctl_pkg::CH_NL) scan_mode = ctl_pkg::MODE_NORMAL;
      end
      ctl_pkg::MODE_LINE_CMT: begin
        if (b == ctl_pkg::CH_NL) scan_mode = ctl_pkg::MODE_NORMAL;
      end
      ctl_pkg::MODE_BLOCK_CMT: begin
        if (b == ctl_pkg::CH_STAR) scan_mode = ctl_pkg::MODE_BLOCK_STAR;
      end
      ctl_pkg::MODE_BLOCK_STAR: begin
        if (b == ctl_pkg::CH_SLASH) scan_mode = ctl_pkg::MODE_NORMAL;
        else if (b != ctl_pkg::CH_STAR) scan_mode = ctl_pkg::MODE_BLOCK_CMT;
      end
      ctl_pkg::MODE_SLASH: begin
        if (b == ctl_pkg::CH_SLASH) scan_mode = ctl_pkg::MODE_LINE_CMT;
        else if (b == ctl_pkg::CH_STAR) scan_mode = ctl_pkg::MODE_BLOCK_CMT;
        else begin
          scan_mode = ctl_pkg::MODE_NORMAL;
          code_byte(b, row, colm);
        end
      end
      default: begin
        scan_mode = ctl_pkg::MODE_NORMAL;
        if (file_head && b == ctl_pkg::CH_HASH) begin
          scan_mode = ctl_pkg::MODE_DIRECTIVE;
        end else begin
          file_head = 1'b0;
          code_byte(b, row, colm);
        end
      end
    endcase
    // position counters, both saturating
    if (b == ctl_pkg::CH_NL) begin
      col_no = 10'd1;
      if (count_line && line_no != 16'hffff) line_no++;
    end else if (col_no != 10'h3ff) begin
      col_no++;
    end
    if (eoi) begin
      flush_lexeme(row);
      reset_lexer();
    end
    for (int k = 0; k < step_toks.size(); k++) begin
      t      = step_toks[k];
      t.last = (k == step_toks.size() - 1);
      token_q.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    src_byte_t e;
    e.ch  = b;
    e.eof = 1'b0;
    byte_q.push_back(e);
  endtask

  task automatic put_text(input string s);
    for (int k = 0; k < s.len(); k++) put_byte(s[k]);
  endtask

  task automatic put_rand(input string pool, input int n);
    repeat (n) put_byte(pool[$urandom_range(0, pool.len() - 1)]);
  endtask

  task automatic close_file();
    src_byte_t e;
    e     = byte_q.pop_back();
    e.eof = 1'b1;
    byte_q.push_back(e);
  endtask

  // One fragment of C-like text, mostly well formed, sometimes noise
  task automatic put_piece();
    case ($urandom_range(0, 15))
      0, 1: begin
        put_text(kw_names[$urandom_range(0, 31)]);
        put_rand(sep_pool, 1);
      end
      2, 3: begin
        put_rand(word_head, 1);
        put_rand(word_tail, $urandom_range(0, 9));
        put_rand(sep_pool, 1);
      end
      4: begin
        put_rand(digits, $urandom_range(1, 6));
        put_rand(sep_pool, 1);
      end
      5: begin
        put_byte(ctl_pkg::CH_QUOTE);
        put_rand(lit_pool, $urandom_range(0, 5));
        put_byte(ctl_pkg::CH_QUOTE);
        put_rand(sep_pool, 1);
      end
      6: put_rand(split_chars, 1);
      7: begin
        put_text($urandom_range(0, 1) ? "&&" : "||");
        put_rand(sep_pool, 1);
      end
      8: begin
        put_text("//");
        put_rand(cmt_pool, $urandom_range(0, 8));
        put_byte(ctl_pkg::CH_NL);
      end
      9: begin
        put_text("/*");
        put_rand(cmt_pool, $urandom_range(0, 8));
        put_text($urandom_range(0, 1) ? "*/" : "**/");
      end
      10: begin
        // lone slash before ordinary text
        put_byte(ctl_pkg::CH_SLASH);
        put_rand(word_head, 1);
        put_rand(sep_pool, 1);
      end
      11: begin
        put_rand(word_tail, $urandom_range(30, 40));
        put_rand(sep_pool, 1);
      end
      12: put_byte(8'($urandom_range(0, 255)));
      13: put_byte(ctl_pkg::CH_TAB);
      14: put_byte(ctl_pkg::CH_NL);
      default: put_text(" = ");
    endcase
  endtask

  task automatic gen_file(input int budget);
    int start;
    start = byte_q.size();
    repeat ($urandom_range(0, 2)) begin
      put_byte(ctl_pkg::CH_HASH);
      put_rand(word_tail, $urandom_range(0, 8));
      put_byte(ctl_pkg::CH_NL);
    end
    while (byte_q.size() - start < budget) put_piece();
    // some files end inside a comment
    case ($urandom_range(0, 7))
      0: put_text("/* open");
      1: put_text("// open");
      default: ;
    endcase
    close_file();
  endtask

  // ---------------------------------------------------------------------------
  // Sender: drives source bytes, predicts on each accepted item
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : feed
    src_byte_t nxt;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) begin
        predict_byte(s_tdata, s_tlast);
        bytes_taken++;
      end
      if (!s_tvalid || s_axis_tready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          nxt = byte_q.pop_front();
          s_tdata  <= nxt.ch;
          s_tlast  <= nxt.eof;
          s_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each token item, applies back-pressure
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40)
      $display("token %0d: %s got %0h expected %0h", tokens_seen, what, got, want);
    mismatches++;
  endtask

  // One long hold-off so the output queue fills and the input stalls
  always @(posedge clk_i) begin : hold_off
    if (rst_ni) begin
      run_cycles <= run_cycles + 1;
      hold_on    <= (run_cycles >= HOLD_AT) && (run_cycles < HOLD_AT + HOLD_CYCLES);
    end
  end

  always @(posedge clk_i) begin : drain
    lex_token_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        if (token_q.size() == 0) begin
          report_mismatch("unexpected token", m_axis_tdata_o[63:0], '0);
        end else begin
          want = token_q.pop_front();
          if (m_axis_tdata_o[3:0] !== want.cls)
            report_mismatch("class", 64'(m_axis_tdata_o[3:0]), 64'(want.cls));
          if (m_axis_tdata_o[8:4] !== want.kw)
            report_mismatch("keyword", 64'(m_axis_tdata_o[8:4]), 64'(want.kw));
          if (m_axis_tdata_o[24:9] !== want.row)
            report_mismatch("row", 64'(m_axis_tdata_o[24:9]), 64'(want.row));
          if (m_axis_tdata_o[34:25] !== want.col)
            report_mismatch("column", 64'(m_axis_tdata_o[34:25]), 64'(want.col));
          if (m_axis_tdata_o[40:35] !== want.len)
            report_mismatch("length", 64'(m_axis_tdata_o[40:35]), 64'(want.len));
          if (m_axis_tdata_o[104:41] !== want.head)
            report_mismatch("head", m_axis_tdata_o[104:41], want.head);
          if (m_axis_tdata_o[111:105] !== '0)
            report_mismatch("padding", 64'(m_axis_tdata_o[111:105]), '0);
          if (m_axis_tlast_o !== want.last)
            report_mismatch("last", 64'(m_axis_tlast_o), 64'(want.last));
        end
        tokens_seen++;
        stall_left = pick_gap();
      end
      if (hold_on) begin
        m_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin
    reset_lexer();

    // head directive, leading and embedded tabs, keyword extremes, literal,
    // block comment closed by a double star, lone slash, line comment,
    // logical, arithmetic and relational tokens, byte extremes at end of file
    put_text("#x\n\tif\t2 auto volatile \"s\"/*a**/a/b//c\n&&+<");
    put_byte(8'h00);
    put_byte(8'hff);
    close_file();

    while (byte_q.size() < 700) gen_file($urandom_range(20, 60));

    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || s_tvalid || token_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
